>>> rtl/core/kpft_pkg.sv
// Shared constants and types for the keyed pair frequency table.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package kpft_pkg;

    localparam int POS_ENTRIES_DEF = 256;
    localparam int MOVES_PER_POS_DEF = 16;

    localparam int KEY_W = 64;
    localparam int MOVE_W = 32;
    localparam int COUNT_W = 32;
    localparam int OPND_W = KEY_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic key_we;
        logic ent_we;
        logic slot_we;
    } tbl_wr_t;

endpackage

`default_nettype wire

>>> rtl/core/kpft_alu.sv
// Shared compare and saturating increment unit of the sequencer.
// Depends on kpft_pkg.
`default_nettype none

module kpft_alu (
    input  wire logic [kpft_pkg::OPND_W-1:0]  opnd_a,
    input  wire logic [kpft_pkg::OPND_W-1:0]  opnd_b,
    output logic                              eq,
    output logic [kpft_pkg::COUNT_W-1:0]      inc
);
    import kpft_pkg::*;

    logic [COUNT_W-1:0] low_a;

    assign low_a = opnd_a[COUNT_W-1:0];
    assign eq    = (opnd_a == opnd_b);
    assign inc   = (low_a == COUNT_MAX) ? low_a : low_a + COUNT_W'(1);

endmodule

`default_nettype wire

>>> rtl/core/kpft_tables.sv
// Position key, entry (total and slot count) and move slot memories.
// Registered reads, one write port each. Depends on kpft_pkg.
`default_nettype none

module kpft_tables #(
    parameter int POSITION_ENTRIES   = kpft_pkg::POS_ENTRIES_DEF,
    parameter int MOVES_PER_POSITION = kpft_pkg::MOVES_PER_POS_DEF,
    localparam int EW  = $clog2(POSITION_ENTRIES),
    localparam int SCW = $clog2(MOVES_PER_POSITION + 1),
    localparam int AW  = $clog2(POSITION_ENTRIES * MOVES_PER_POSITION),
    localparam int ENT_W = kpft_pkg::COUNT_W + SCW,
    localparam int SLOT_W = kpft_pkg::MOVE_W + kpft_pkg::COUNT_W
) (
    input  wire logic                          aclk,
    input  wire kpft_pkg::tbl_wr_t             wr,
    input  wire logic [EW-1:0]                 key_raddr,
    input  wire logic [EW-1:0]                 key_waddr,
    input  wire logic [kpft_pkg::KEY_W-1:0]    key_wdata,
    output logic [kpft_pkg::KEY_W-1:0]         key_rdata,
    input  wire logic [EW-1:0]                 ent_addr,
    input  wire logic [ENT_W-1:0]              ent_wdata,
    output logic [ENT_W-1:0]                   ent_rdata,
    input  wire logic [AW-1:0]                 slot_raddr,
    input  wire logic [AW-1:0]                 slot_waddr,
    input  wire logic [SLOT_W-1:0]             slot_wdata,
    output logic [SLOT_W-1:0]                  slot_rdata
);
    import kpft_pkg::*;

    localparam int SLOT_DEPTH = POSITION_ENTRIES * MOVES_PER_POSITION;

    logic [KEY_W-1:0]  key_mem  [POSITION_ENTRIES];
    logic [ENT_W-1:0]  ent_mem  [POSITION_ENTRIES];
    logic [SLOT_W-1:0] slot_mem [SLOT_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr.ent_we) begin
            ent_mem[ent_addr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[ent_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata <= slot_mem[slot_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/keyed_pair_frequency_table_unit.sv
// Keyed pair frequency table: sequencer over the table memories and shared unit.
// The key scan and the slot scan read one memory word a cycle.
// Throughput: one item at a time, s_ready high only while idle. Synchronous active-low
// reset empties the table and clears the result valid flag; no clearing pass is needed.
`default_nettype none

module keyed_pair_frequency_table_unit #(
    parameter int POSITION_ENTRIES   = kpft_pkg::POS_ENTRIES_DEF,
    parameter int MOVES_PER_POSITION = kpft_pkg::MOVES_PER_POS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [kpft_pkg::KEY_W-1:0]     s_position_key,
    input  wire logic [kpft_pkg::MOVE_W-1:0]    s_move_code,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [kpft_pkg::COUNT_W-1:0]        m_move_count,
    output logic [kpft_pkg::COUNT_W-1:0]        m_position_total,
    output logic                                m_new_position,
    output logic                                m_new_move,
    output logic                                m_dropped
);
    import kpft_pkg::*;

    localparam int EW  = $clog2(POSITION_ENTRIES);
    localparam int PCW = $clog2(POSITION_ENTRIES + 1);
    localparam int SCW = $clog2(MOVES_PER_POSITION + 1);
    localparam int AW  = $clog2(POSITION_ENTRIES * MOVES_PER_POSITION);
    localparam int ENT_W = COUNT_W + SCW;
    localparam int SLOT_W = MOVE_W + COUNT_W;
    localparam logic [PCW-1:0] POS_FULL = PCW'(POSITION_ENTRIES);
    localparam logic [SCW-1:0] SLOT_FULL = SCW'(MOVES_PER_POSITION);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KSCAN,
        ST_ENT_RD,
        ST_ENT_WAIT,
        ST_MSCAN,
        ST_INC_CNT,
        ST_INC_TOT,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic [MOVE_W-1:0]  mv_reg, mv_next;
    logic [PCW-1:0]     pos_used_reg, pos_used_next;
    logic [PCW-1:0]     kidx_reg, kidx_next;
    logic [PCW-1:0]     kpidx_reg, kpidx_next;
    logic [SCW-1:0]     sidx_reg, sidx_next;
    logic [SCW-1:0]     spidx_reg, spidx_next;
    logic               pend_reg, pend_next;
    logic [EW-1:0]      entry_reg, entry_next;
    logic [AW-1:0]      base_reg, base_next;
    logic               fresh_reg, fresh_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [SCW-1:0]     used_reg, used_next;
    logic [SCW-1:0]     slot_reg, slot_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               append_reg, append_next;
    logic               drop_reg, drop_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_move_count_reg, m_move_count_next;
    logic [COUNT_W-1:0] m_position_total_reg, m_position_total_next;
    logic               m_new_position_reg, m_new_position_next;
    logic               m_new_move_reg, m_new_move_next;
    logic               m_dropped_reg, m_dropped_next;

    tbl_wr_t            wr;
    logic [KEY_W-1:0]   key_rdata;
    logic [ENT_W-1:0]   ent_wdata, ent_rdata;
    logic [AW-1:0]      slot_raddr, slot_waddr;
    logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
    logic [OPND_W-1:0]  opnd_a, opnd_b;
    logic               alu_eq;
    logic [COUNT_W-1:0] alu_inc;
    logic               k_issue, s_issue;

    kpft_tables #(
        .POSITION_ENTRIES   (POSITION_ENTRIES),
        .MOVES_PER_POSITION (MOVES_PER_POSITION)
    ) u_tables (
        .aclk       (aclk),
        .wr         (wr),
        .key_raddr  (kidx_reg[EW-1:0]),
        .key_waddr  (pos_used_reg[EW-1:0]),
        .key_wdata  (key_reg),
        .key_rdata  (key_rdata),
        .ent_addr   (entry_reg),
        .ent_wdata  (ent_wdata),
        .ent_rdata  (ent_rdata),
        .slot_raddr (slot_raddr),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_rdata (slot_rdata)
    );

    kpft_alu u_alu (
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .eq     (alu_eq),
        .inc    (alu_inc)
    );

    assign k_issue    = (kidx_reg < pos_used_reg);
    assign s_issue    = (sidx_reg < used_reg);
    assign slot_raddr = base_reg + AW'(sidx_reg);
    assign slot_waddr = base_reg + AW'(slot_reg);
    assign slot_wdata = {mv_reg, alu_inc};
    assign ent_wdata  = {alu_inc, used_reg + SCW'(append_reg)};

    always_comb begin
        case (state_reg)
            ST_KSCAN: begin
                opnd_a = key_rdata;
                opnd_b = key_reg;
            end
            ST_MSCAN: begin
                opnd_a = OPND_W'(slot_rdata[SLOT_W-1:COUNT_W]);
                opnd_b = OPND_W'(mv_reg);
            end
            ST_INC_CNT: begin
                opnd_a = OPND_W'(cnt_reg);
                opnd_b = OPND_W'(mv_reg);
            end
            default: begin
                opnd_a = OPND_W'(total_reg);
                opnd_b = OPND_W'(mv_reg);
            end
        endcase
    end

    always_comb begin
        state_next            = state_reg;
        key_next              = key_reg;
        mv_next               = mv_reg;
        pos_used_next         = pos_used_reg;
        kidx_next             = kidx_reg;
        kpidx_next            = kpidx_reg;
        sidx_next             = sidx_reg;
        spidx_next            = spidx_reg;
        pend_next             = pend_reg;
        entry_next            = entry_reg;
        base_next             = base_reg;
        fresh_next            = fresh_reg;
        total_next            = total_reg;
        used_next             = used_reg;
        slot_next             = slot_reg;
        cnt_next              = cnt_reg;
        append_next           = append_reg;
        drop_next             = drop_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_move_count_next     = m_move_count_reg;
        m_position_total_next = m_position_total_reg;
        m_new_position_next   = m_new_position_reg;
        m_new_move_next       = m_new_move_reg;
        m_dropped_next        = m_dropped_reg;
        wr                    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next    = s_position_key;
                    mv_next     = s_move_code;
                    kidx_next   = '0;
                    pend_next   = 1'b0;
                    append_next = 1'b0;
                    drop_next   = 1'b0;
                    state_next  = ST_KSCAN;
                end
            end
            ST_KSCAN: begin
                if (pend_reg && alu_eq) begin
                    entry_next = kpidx_reg[EW-1:0];
                    fresh_next = 1'b0;
                    state_next = ST_ENT_RD;
                end else if (!k_issue && !pend_reg) begin
                    if (pos_used_reg == POS_FULL) begin
                        cnt_next    = '0;
                        total_next  = '0;
                        fresh_next  = 1'b0;
                        drop_next   = 1'b1;
                        state_next  = ST_RESP;
                    end else begin
                        wr.key_we     = 1'b1;
                        entry_next    = pos_used_reg[EW-1:0];
                        pos_used_next = pos_used_reg + PCW'(1);
                        fresh_next    = 1'b1;
                        state_next    = ST_ENT_RD;
                    end
                end else begin
                    pend_next = k_issue;
                    if (k_issue) begin
                        kpidx_next = kidx_reg;
                        kidx_next  = kidx_reg + PCW'(1);
                    end
                end
            end
            ST_ENT_RD: begin
                base_next  = AW'(entry_reg * MOVES_PER_POSITION);
                state_next = ST_ENT_WAIT;
            end
            ST_ENT_WAIT: begin
                total_next = fresh_reg ? '0 : ent_rdata[ENT_W-1:SCW];
                used_next  = fresh_reg ? '0 : ent_rdata[SCW-1:0];
                sidx_next  = '0;
                pend_next  = 1'b0;
                state_next = ST_MSCAN;
            end
            ST_MSCAN: begin
                if (pend_reg && alu_eq) begin
                    slot_next  = spidx_reg;
                    cnt_next   = slot_rdata[COUNT_W-1:0];
                    state_next = ST_INC_CNT;
                end else if (!s_issue && !pend_reg) begin
                    if (used_reg == SLOT_FULL) begin
                        cnt_next   = '0;
                        total_next = '0;
                        fresh_next = 1'b0;
                        drop_next  = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        slot_next   = used_reg;
                        cnt_next    = '0;
                        append_next = 1'b1;
                        state_next  = ST_INC_CNT;
                    end
                end else begin
                    pend_next = s_issue;
                    if (s_issue) begin
                        spidx_next = sidx_reg;
                        sidx_next  = sidx_reg + SCW'(1);
                    end
                end
            end
            ST_INC_CNT: begin
                wr.slot_we = 1'b1;
                cnt_next   = alu_inc;
                state_next = ST_INC_TOT;
            end
            ST_INC_TOT: begin
                wr.ent_we  = 1'b1;
                total_next = alu_inc;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_move_count_next     = cnt_reg;
                    m_position_total_next = total_reg;
                    m_new_position_next   = fresh_reg;
                    m_new_move_next       = append_reg;
                    m_dropped_next        = drop_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_used_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_used_reg <= pos_used_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
        key_reg              <= key_next;
        mv_reg               <= mv_next;
        kidx_reg             <= kidx_next;
        kpidx_reg            <= kpidx_next;
        sidx_reg             <= sidx_next;
        spidx_reg            <= spidx_next;
        entry_reg            <= entry_next;
        base_reg             <= base_next;
        fresh_reg            <= fresh_next;
        total_reg            <= total_next;
        used_reg             <= used_next;
        slot_reg             <= slot_next;
        cnt_reg              <= cnt_next;
        append_reg           <= append_next;
        drop_reg             <= drop_next;
        m_move_count_reg     <= m_move_count_next;
        m_position_total_reg <= m_position_total_next;
        m_new_position_reg   <= m_new_position_next;
        m_new_move_reg       <= m_new_move_next;
        m_dropped_reg        <= m_dropped_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_move_count     = m_move_count_reg;
    assign m_position_total = m_position_total_reg;
    assign m_new_position   = m_new_position_reg;
    assign m_new_move       = m_new_move_reg;
    assign m_dropped        = m_dropped_reg;

endmodule

`default_nettype wire

>>> tb/frequency_table_checker.sv
// Checker for the keyed pair frequency table: watches both channels, keeps its own
// copy of the position and move tables, and compares each result with its prediction.
// Depends on kpft_pkg for widths and the count ceiling.
`timescale 1ns / 100ps

module frequency_table_checker #(
    parameter int ENTRIES = kpft_pkg::POS_ENTRIES_DEF,
    parameter int SLOTS   = kpft_pkg::MOVES_PER_POS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [kpft_pkg::KEY_W-1:0]   s_position_key,
    input  logic [kpft_pkg::MOVE_W-1:0]  s_move_code,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [kpft_pkg::COUNT_W-1:0] m_move_count,
    input  logic [kpft_pkg::COUNT_W-1:0] m_position_total,
    input  logic                         m_new_position,
    input  logic                         m_new_move,
    input  logic                         m_dropped,
    input  logic                         wrap_up,
    output int                           pending_count,
    output int                           checked_count,
    output int                           dropped_count,
    output int                           fail_count
);

    typedef struct {
        logic [kpft_pkg::COUNT_W-1:0] move_count;
        logic [kpft_pkg::COUNT_W-1:0] position_total;
        logic                         new_position;
        logic                         new_move;
        logic                         dropped;
    } tally_t;

    logic [kpft_pkg::KEY_W-1:0]   key_tab [ENTRIES];
    bit                           key_live [ENTRIES];
    logic [kpft_pkg::COUNT_W-1:0] pos_sum [ENTRIES];
    int                           slot_fill [ENTRIES];
    logic [kpft_pkg::MOVE_W-1:0]  slot_move [ENTRIES][SLOTS];
    logic [kpft_pkg::COUNT_W-1:0] slot_freq [ENTRIES][SLOTS];
    int                           live_entries = 0;

    tally_t pending_tallies [$];
    int     pending_seen = 0;
    int     mismatches = 0;
    int     checked = 0;
    int     drops = 0;
    bit     wrapped = 0;

    assign pending_count = pending_seen;
    assign fail_count    = mismatches;
    assign checked_count = checked;
    assign dropped_count = drops;

    function automatic logic [kpft_pkg::COUNT_W-1:0] sat_bump(
        logic [kpft_pkg::COUNT_W-1:0] v);
        return (v == kpft_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic tally_t tally_move(logic [kpft_pkg::KEY_W-1:0] key,
                                          logic [kpft_pkg::MOVE_W-1:0] mv);
        tally_t r;
        int     e;
        bit     hit;
        bit     fresh;
        r = '{default: '0};
        e = 0;
        hit = 0;
        fresh = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && key_live[i] && key_tab[i] == key) begin
                hit = 1;
                e = i;
            end
        end
        if (!hit) begin
            if (live_entries >= ENTRIES) begin
                r.dropped = 1'b1;
                return r;
            end
            e = live_entries;
            key_tab[e]   = key;
            key_live[e]  = 1;
            pos_sum[e]   = '0;
            slot_fill[e] = 0;
            live_entries++;
            fresh = 1;
        end
        for (int s = 0; s < slot_fill[e]; s++) begin
            if (slot_move[e][s] == mv) begin
                slot_freq[e][s]  = sat_bump(slot_freq[e][s]);
                pos_sum[e]       = sat_bump(pos_sum[e]);
                r.move_count     = slot_freq[e][s];
                r.position_total = pos_sum[e];
                r.new_position   = fresh;
                return r;
            end
        end
        if (slot_fill[e] >= SLOTS) begin
            r.dropped = 1'b1;
            return r;
        end
        slot_move[e][slot_fill[e]] = mv;
        slot_freq[e][slot_fill[e]] = 1;
        slot_fill[e]++;
        pos_sum[e]       = sat_bump(pos_sum[e]);
        r.move_count     = 1;
        r.position_total = pos_sum[e];
        r.new_position   = fresh;
        r.new_move       = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      checked, name, got, want));
    endtask

    always @(posedge aclk) begin
        tally_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_tallies.insert(pending_tallies.size(),
                                       tally_move(s_position_key, s_move_code));
            if (m_valid && m_ready) begin
                if (pending_tallies.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = pending_tallies.pop_front();
                    check_field("move_count", m_move_count, want.move_count);
                    check_field("position_total", m_position_total, want.position_total);
                    check_field("new_position", 32'(m_new_position), 32'(want.new_position));
                    check_field("new_move", 32'(m_new_move), 32'(want.new_move));
                    check_field("dropped", 32'(m_dropped), 32'(want.dropped));
                    checked++;
                    if (want.dropped)
                        drops++;
                end
            end
            if (wrap_up && !wrapped) begin
                wrapped = 1;
                if (pending_tallies.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              pending_tallies.size()));
            end
            pending_seen <= pending_tallies.size();
        end
    end

endmodule

>>> tb/tb_keyed_pair_frequency_table_unit.sv
// Top of the keyed pair frequency table testbench: clock, reset, item and ready stimulus.
// Depends on kpft_pkg, keyed_pair_frequency_table_unit and frequency_table_checker.
`timescale 1ns / 100ps

module tb_keyed_pair_frequency_table_unit;

    localparam int RANDOM_ITEMS = 550;
    localparam int QUIET_TAIL   = 60;
    localparam int FRESH_CAP    = 320;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT        = 1_000_000;
    localparam logic [kpft_pkg::KEY_W-1:0] FULL_KEY = 64'h5555_5555_5555_5555;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [kpft_pkg::KEY_W-1:0]   s_position_key = '0;
    logic [kpft_pkg::MOVE_W-1:0]  s_move_code = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [kpft_pkg::COUNT_W-1:0] m_move_count;
    logic [kpft_pkg::COUNT_W-1:0] m_position_total;
    logic                         m_new_position;
    logic                         m_new_move;
    logic                         m_dropped;

    logic wrap_up = 1'b0;
    logic quiet_mode = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   fresh_keys = 0;
    int   pending_count;
    int   checked_count;
    int   dropped_count;
    int   fail_count;

    logic [kpft_pkg::KEY_W-1:0]  hot_keys [8];
    logic [kpft_pkg::MOVE_W-1:0] move_pool [24];

    keyed_pair_frequency_table_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_position_key   (s_position_key),
        .s_move_code      (s_move_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_move_count     (m_move_count),
        .m_position_total (m_position_total),
        .m_new_position   (m_new_position),
        .m_new_move       (m_new_move),
        .m_dropped        (m_dropped)
    );

    frequency_table_checker CHECKER (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_position_key   (s_position_key),
        .s_move_code      (s_move_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_move_count     (m_move_count),
        .m_position_total (m_position_total),
        .m_new_position   (m_new_position),
        .m_new_move       (m_new_move),
        .m_dropped        (m_dropped),
        .wrap_up          (wrap_up),
        .pending_count    (pending_count),
        .checked_count    (checked_count),
        .dropped_count    (dropped_count),
        .fail_count       (fail_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_count);
        $display("*** FAILED ***");
        $finish;
    end

    // Hold off for one long stretch, stay ready in quiet mode, otherwise stall in short random bursts.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (quiet_mode) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [kpft_pkg::KEY_W-1:0] key,
                             logic [kpft_pkg::MOVE_W-1:0] mv);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_position_key <= key;
        s_move_code <= mv;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (items_sent == HOLD_AT)
            hold_req <= 1'b1;
    endtask

    initial begin
        logic [kpft_pkg::KEY_W-1:0]  key;
        logic [kpft_pkg::MOVE_W-1:0] mv;

        hot_keys[0] = '0;
        hot_keys[1] = FULL_KEY;
        for (int i = 2; i < 8; i++)
            hot_keys[i] = {$urandom, $urandom};
        move_pool[0] = '0;
        move_pool[1] = '1;
        for (int i = 2; i < 24; i++)
            move_pool[i] = $urandom;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, repeats, then fill one entry's move slots past the end.
        send_item('0, '0);
        send_item('1, '1);
        send_item('0, '0);
        send_item('1, '0);
        send_item('0, '1);
        for (int i = 0; i <= kpft_pkg::MOVES_PER_POS_DEF; i++)
            send_item(FULL_KEY, i);
        send_item(FULL_KEY, 3);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);

        // Mostly new keys until past table overflow, the rest on a few hot keys.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet_mode <= 1'b1;
            if (fresh_keys < FRESH_CAP && $urandom_range(0, 99) < 65) begin
                key = {$urandom, $urandom};
                fresh_keys++;
            end else begin
                key = hot_keys[$urandom_range(0, 7)];
            end
            if ($urandom_range(0, 4) == 0)
                mv = $urandom;
            else
                mv = move_pool[$urandom_range(0, 23)];
            send_item(key, mv);
        end
        s_valid <= 1'b0;

        while (pending_count != 0 || checked_count != items_sent)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("Sent %0d items, %0d of them on fresh random keys; %0d results checked.",
                 items_sent, fresh_keys, checked_count);
        $display("%0d results were drops from a full table or full move slots.",
                 dropped_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
